// ===== rtl/spi_serial_flash_device_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the serial flash device
// Property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SPI_SERIAL_FLASH_DEVICE_DEFINES_SVH
`define SPI_SERIAL_FLASH_DEVICE_DEFINES_SVH

// Checked only while reset is released.
`define SFD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define SFD_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial flash device package
// Types, codes and constants shared by the serial flash device modules.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int FLASH_BYTES_DEF = 65536;
  localparam int PTR_W           = 24;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 24;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_ID_BYTES   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUSY_POLLS = 1'b1;

  localparam logic [23:0] ID_BYTES_RST   = 24'd12722200;
  localparam logic [3:0]  BUSY_POLLS_RST = 4'd10;

  localparam logic [7:0] OFS_BUSY      = 8'h04;
  localparam logic [7:0] OFS_MODE      = 8'h10;
  localparam logic [7:0] OFS_TX        = 8'h18;
  localparam logic [7:0] OFS_RX        = 8'h1C;
  localparam logic [7:0] OFS_MODE_WORD = 8'h38;

  localparam int WEL_BIT = 1;

  typedef enum logic [1:0] {
    FN_BUS_RD  = 2'd0,
    FN_BUS_WR  = 2'd1,
    FN_CS      = 2'd2,
    FN_PRELOAD = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_BUSY_RD,
    OP_MODE_WORD_RD,
    OP_RECEIVE,
    OP_TRANSMIT,
    OP_MODE_WORD_WR,
    OP_CS_HIGH,
    OP_PRELOAD
  } op_t;

  typedef enum logic [7:0] {
    CMD_STANDBY = 8'h00,
    CMD_WRSR    = 8'h01,
    CMD_RDSR    = 8'h05,
    CMD_POLL    = 8'h08,
    CMD_WREN    = 8'h06,
    CMD_WRDI    = 8'h04,
    CMD_RDID    = 8'h9F,
    CMD_READ    = 8'h03,
    CMD_QREAD   = 8'h6B,
    CMD_PP      = 8'h02,
    CMD_ARRAY   = 8'h07
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_OPCODE = 2'd1,
    ERR_WRITE  = 2'd2,
    ERR_READ   = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    ENG_CLEAR,
    ENG_IDLE,
    ENG_MOD,
    ENG_MEM,
    ENG_RESP
  } eng_state_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
    logic [15:0] load_address;
  } sfd_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    err_t        error;
  } sfd_resp_t;

  function automatic logic [7:0] id_byte(input logic [23:0] ids, input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = ids[23:16];
      2'd1:    b = ids[15:8];
      2'd2:    b = ids[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/sfd_if.sv =====
// ----------------------------------------------------------------------------
// Serial flash device channels
// Valid/ready interfaces for the request and result words.
// ----------------------------------------------------------------------------
interface sfd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  offset;
  logic [31:0] value;
  logic [15:0] load_address;

  modport source (output valid, output func, output offset, output value,
                  output load_address, input ready);
  modport sink (input valid, input func, input offset, input value,
                input load_address, output ready);
endinterface

interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [1:0]  error;

  modport source (output valid, output read_data, output error, input ready);
  modport sink (input valid, input read_data, input error, output ready);
endinterface

// ===== rtl/sfd_front.sv =====
// ----------------------------------------------------------------------------
// Serial flash device front end
// Accepts request words, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module sfd_front (
  input  logic              clk,
  input  logic              rst_n,
  sfd_in_if.sink            in_ch,
  input  logic              hold,
  output logic              q_valid,
  output sfd_pkg::sfd_item_t q_item,
  input  logic              q_pop
);

  localparam logic [sfd_pkg::QUEUE_AW:0] QFULL = (sfd_pkg::QUEUE_AW+1)'(sfd_pkg::QUEUE_DEPTH);

  sfd_pkg::sfd_item_t           slot_r [sfd_pkg::QUEUE_DEPTH];
  logic [sfd_pkg::QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [sfd_pkg::QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [sfd_pkg::QUEUE_AW:0]   cnt_r, cnt_nxt;
  logic                         push;
  sfd_pkg::op_t                 op_c;
  sfd_pkg::sfd_item_t           item_c;

  assign in_ch.ready = !hold && (cnt_r != QFULL);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign q_item      = slot_r[rd_ptr_r];

  always_comb begin
    op_c = sfd_pkg::OP_NOP;
    case (sfd_pkg::func_t'(in_ch.func))
      sfd_pkg::FN_BUS_RD: begin
        if (in_ch.offset == sfd_pkg::OFS_BUSY) op_c = sfd_pkg::OP_BUSY_RD;
        else if (in_ch.offset == sfd_pkg::OFS_RX) op_c = sfd_pkg::OP_RECEIVE;
        else if (in_ch.offset == sfd_pkg::OFS_MODE_WORD) op_c = sfd_pkg::OP_MODE_WORD_RD;
      end
      sfd_pkg::FN_BUS_WR: begin
        if (in_ch.offset == sfd_pkg::OFS_TX) op_c = sfd_pkg::OP_TRANSMIT;
        else if (in_ch.offset == sfd_pkg::OFS_MODE_WORD) op_c = sfd_pkg::OP_MODE_WORD_WR;
      end
      sfd_pkg::FN_CS: begin
        if (in_ch.value[0]) op_c = sfd_pkg::OP_CS_HIGH;
      end
      sfd_pkg::FN_PRELOAD: begin
        op_c = sfd_pkg::OP_PRELOAD;
      end
      default: begin
        op_c = sfd_pkg::OP_NOP;
      end
    endcase
    item_c.op           = op_c;
    item_c.value        = in_ch.value;
    item_c.load_address = in_ch.load_address;
  end

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push, q_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_c;
    end
  end

endmodule

// ===== rtl/sfd_mod.sv =====
// ----------------------------------------------------------------------------
// Serial flash device address reduction
// Reduces a 24-bit address modulo the flash size with a reciprocal
// multiplication, a multiply-back and one compare and subtract, pipelined
// through the registers q1_r, t2_r and rem_r, when the size is not a power
// of two and the address is out of range.
// ----------------------------------------------------------------------------
module sfd_mod #(
  parameter int FLASH_BYTES = sfd_pkg::FLASH_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [sfd_pkg::PTR_W-1:0]       x,
  output logic                            quick,
  output logic [$clog2(FLASH_BYTES)-1:0]  fast_r,
  output logic                            done,
  output logic [$clog2(FLASH_BYTES)-1:0]  r
);

  localparam int AW = $clog2(FLASH_BYTES);
  localparam int XW = sfd_pkg::PTR_W + 1;
  localparam bit POW2 = (FLASH_BYTES == (1 << AW));
  localparam int RECIP = (1 << sfd_pkg::PTR_W) / FLASH_BYTES;
  localparam int RW = $clog2(RECIP + 1);
  localparam int PW = sfd_pkg::PTR_W + RW;
  localparam logic [RW-1:0] RECIP_R = RW'(RECIP);
  localparam logic [XW-1:0] N_X = XW'(FLASH_BYTES);

  logic [PW-1:0]             prod;
  logic [XW-1:0]             qn;
  logic [XW-1:0]             t_c;
  logic [XW-1:0]             fix_c;
  logic [sfd_pkg::PTR_W-1:0] x1_r;
  logic [RW-1:0]             q1_r;
  logic [XW-1:0]             t2_r;
  logic [AW-1:0]             rem_r;
  logic                      v1_r;
  logic                      v2_r;
  logic                      done_r;

  assign quick  = POW2 || ({1'b0, x} < N_X);
  assign fast_r = x[AW-1:0];
  assign done   = done_r;
  assign r      = rem_r;

  // The quotient estimate is low by at most one, so one subtract finishes it.
  always_comb begin
    prod  = PW'(x) * PW'(RECIP_R);
    qn    = XW'(q1_r) * N_X;
    t_c   = {1'b0, x1_r} - qn;
    fix_c = (t2_r >= N_X) ? t2_r - N_X : t2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    x1_r  <= x;
    q1_r  <= prod[PW-1:sfd_pkg::PTR_W];
    t2_r  <= t_c;
    rem_r <= fix_c[AW-1:0];
  end

endmodule

// ===== rtl/sfd_engine.sv =====
// ----------------------------------------------------------------------------
// Serial flash device engine
// Executes queued words against the command state and the flash array and
// holds the result word until it is taken.
// ----------------------------------------------------------------------------
module sfd_engine #(
  parameter int FLASH_BYTES = sfd_pkg::FLASH_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              q_valid,
  input  sfd_pkg::sfd_item_t                q_item,
  output logic                              q_pop,
  output logic                              clearing,
  sfd_out_if.source                         out_ch
);

  localparam int AW = $clog2(FLASH_BYTES);
  localparam int MW = AW + 1;
  localparam logic [MW-1:0] N_M = MW'(FLASH_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(FLASH_BYTES - 1);

  sfd_pkg::eng_state_t state_r, state_nxt;
  sfd_pkg::sfd_item_t  cur_r, cur_nxt;
  sfd_pkg::cmd_t       cmd_r, cmd_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic [sfd_pkg::PTR_W-1:0] ptr_r, ptr_nxt;
  logic [7:0]          pending_r, pending_nxt;
  logic [7:0]          status_r, status_nxt;
  logic [3:0]          bpl_r, bpl_nxt;
  logic [31:0]         mode_word_r, mode_word_nxt;
  logic [23:0]         id_r, id_nxt;
  logic [3:0]          bpc_r, bpc_nxt;
  sfd_pkg::sfd_resp_t  resp_r, resp_nxt;
  sfd_pkg::sfd_resp_t  out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;

  logic [7:0]          mem [FLASH_BYTES];
  logic [7:0]          rdata_r;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_addr;
  logic [7:0]          mem_wdata;

  logic                      mod_start, mod_quick, mod_done;
  logic [sfd_pkg::PTR_W-1:0] mod_x;
  logic [AW-1:0]             mod_fast_r, mod_r;

  sfd_pkg::sfd_item_t        it;
  logic [7:0]                tx_byte;
  logic [1:0]                ph_inc;
  logic                      addr_cmd;
  logic [sfd_pkg::PTR_W-1:0] addr_part, ptr_full;
  logic [AW-1:0]             red_r, red_wrap, ptr_wrap;
  logic [MW-1:0]             red_inc, ptr_inc;
  logic                      need_red, red_go;

  sfd_mod #(.FLASH_BYTES(FLASH_BYTES)) u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mod_start),
    .x      (mod_x),
    .quick  (mod_quick),
    .fast_r (mod_fast_r),
    .done   (mod_done),
    .r      (mod_r)
  );

  assign clearing        = (state_r == sfd_pkg::ENG_CLEAR);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_r.read_data;
  assign out_ch.error     = out_r.error;

  always_comb begin
    id_nxt  = id_r;
    bpc_nxt = bpc_r;
    if (cfg_we) begin
      case (cfg_index)
        sfd_pkg::CFG_ID_BYTES:   id_nxt  = cfg_data[23:0];
        sfd_pkg::CFG_BUSY_POLLS: bpc_nxt = cfg_data[3:0];
        default: begin
          id_nxt = id_r;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    cmd_nxt       = cmd_r;
    phase_nxt     = phase_r;
    ptr_nxt       = ptr_r;
    pending_nxt   = pending_r;
    status_nxt    = status_r;
    bpl_nxt       = bpl_r;
    mode_word_nxt = mode_word_r;
    resp_nxt      = resp_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = '0;
    mem_wdata     = '0;
    mod_start     = 1'b0;
    mod_x         = ptr_r;
    need_red      = 1'b0;
    red_go        = 1'b0;

    it       = (state_r == sfd_pkg::ENG_IDLE) ? q_item : cur_r;
    tx_byte  = it.value[7:0];
    ph_inc   = phase_r + 2'd1;
    addr_cmd = (cmd_r == sfd_pkg::CMD_READ) || (cmd_r == sfd_pkg::CMD_PP) ||
               (cmd_r == sfd_pkg::CMD_ARRAY) || (cmd_r == sfd_pkg::CMD_QREAD);
    case (phase_r)
      2'd0:    addr_part = {tx_byte, 16'h0000};
      2'd1:    addr_part = {8'h00, tx_byte, 8'h00};
      default: addr_part = {16'h0000, tx_byte};
    endcase
    ptr_full = ptr_r | addr_part;

    red_r    = (state_r == sfd_pkg::ENG_MOD) ? mod_r : mod_fast_r;
    red_inc  = {1'b0, red_r} + MW'(1);
    red_wrap = (red_inc >= N_M) ? '0 : red_inc[AW-1:0];
    ptr_inc  = {1'b0, ptr_r[AW-1:0]} + MW'(1);
    ptr_wrap = (ptr_inc >= N_M) ? '0 : ptr_inc[AW-1:0];

    case (state_r)
      sfd_pkg::ENG_CLEAR: begin
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = sfd_pkg::ENG_IDLE;
        end
      end
      sfd_pkg::ENG_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_item;
          state_nxt = sfd_pkg::ENG_RESP;
          resp_nxt  = '{read_data: 32'h0, error: sfd_pkg::ERR_NONE};
          case (q_item.op)
            sfd_pkg::OP_BUSY_RD: begin
              if (bpl_r != '0) begin
                bpl_nxt            = bpl_r - 1'b1;
                resp_nxt.read_data = 32'd1;
              end
            end
            sfd_pkg::OP_MODE_WORD_RD: begin
              resp_nxt.read_data = mode_word_r;
            end
            sfd_pkg::OP_MODE_WORD_WR: begin
              mode_word_nxt = q_item.value;
            end
            sfd_pkg::OP_CS_HIGH: begin
              ptr_nxt     = '1;
              cmd_nxt     = sfd_pkg::CMD_STANDBY;
              phase_nxt   = '0;
              pending_nxt = '0;
              bpl_nxt     = '0;
            end
            sfd_pkg::OP_PRELOAD: begin
              need_red = 1'b1;
              mod_x    = sfd_pkg::PTR_W'(q_item.load_address);
            end
            sfd_pkg::OP_RECEIVE: begin
              resp_nxt.read_data = {24'h0, pending_r};
              case (cmd_r)
                sfd_pkg::CMD_READ, sfd_pkg::CMD_QREAD: begin
                  need_red = 1'b1;
                  mod_x    = ptr_r;
                  bpl_nxt  = bpc_r;
                end
                sfd_pkg::CMD_RDSR: begin
                  cmd_nxt = sfd_pkg::CMD_STANDBY;
                end
                sfd_pkg::CMD_RDID: begin
                  pending_nxt = sfd_pkg::id_byte(id_r, ph_inc);
                  if (ph_inc == 2'd3) begin
                    cmd_nxt   = sfd_pkg::CMD_STANDBY;
                    phase_nxt = '0;
                  end else begin
                    phase_nxt = ph_inc;
                  end
                end
                default: begin
                  resp_nxt.error = sfd_pkg::ERR_READ;
                  pending_nxt    = '0;
                end
              endcase
            end
            sfd_pkg::OP_TRANSMIT: begin
              if (cmd_r == sfd_pkg::CMD_STANDBY) begin
                case (tx_byte)
                  sfd_pkg::CMD_WRSR: begin
                    cmd_nxt    = sfd_pkg::CMD_WRSR;
                    status_nxt = '0;
                  end
                  sfd_pkg::CMD_RDSR: begin
                    pending_nxt = status_r;
                    cmd_nxt     = sfd_pkg::CMD_RDSR;
                  end
                  sfd_pkg::CMD_POLL: begin
                    pending_nxt = {7'h00, (bpl_r != '0)};
                    if (bpl_r != '0) bpl_nxt = bpl_r - 1'b1;
                  end
                  sfd_pkg::CMD_WREN: begin
                    status_nxt[sfd_pkg::WEL_BIT] = 1'b1;
                  end
                  sfd_pkg::CMD_WRDI: begin
                    status_nxt[sfd_pkg::WEL_BIT] = 1'b0;
                  end
                  sfd_pkg::CMD_RDID: begin
                    pending_nxt = sfd_pkg::id_byte(id_r, 2'd0);
                    cmd_nxt     = sfd_pkg::CMD_RDID;
                    phase_nxt   = '0;
                  end
                  sfd_pkg::CMD_READ, sfd_pkg::CMD_PP, sfd_pkg::CMD_ARRAY,
                  sfd_pkg::CMD_QREAD: begin
                    cmd_nxt   = sfd_pkg::cmd_t'(tx_byte);
                    phase_nxt = '0;
                    ptr_nxt   = '0;
                    bpl_nxt   = '0;
                  end
                  default: begin
                    resp_nxt.error = sfd_pkg::ERR_OPCODE;
                  end
                endcase
              end else if (cmd_r == sfd_pkg::CMD_WRSR) begin
                status_nxt = tx_byte;
                cmd_nxt    = sfd_pkg::CMD_STANDBY;
                phase_nxt  = '0;
              end else if (cmd_r == sfd_pkg::CMD_PP && phase_r == 2'd3) begin
                mem_we    = 1'b1;
                mem_addr  = ptr_r[AW-1:0];
                mem_wdata = tx_byte;
                cmd_nxt   = sfd_pkg::CMD_STANDBY;
                phase_nxt = '0;
              end else if (cmd_r == sfd_pkg::CMD_ARRAY && phase_r == 2'd3) begin
                mem_we    = 1'b1;
                mem_addr  = ptr_r[AW-1:0];
                mem_wdata = tx_byte;
                ptr_nxt   = sfd_pkg::PTR_W'(ptr_wrap);
              end else if (addr_cmd && phase_r != 2'd3) begin
                ptr_nxt   = ptr_full;
                phase_nxt = ph_inc;
                bpl_nxt   = bpc_r;
                if (ph_inc == 2'd3) begin
                  need_red = 1'b1;
                  mod_x    = ptr_full;
                end
              end else begin
                resp_nxt.error = sfd_pkg::ERR_WRITE;
              end
            end
            default: begin
              resp_nxt.read_data = 32'h0;
            end
          endcase
          if (need_red) begin
            if (mod_quick) begin
              red_go = 1'b1;
            end else begin
              mod_start = 1'b1;
              state_nxt = sfd_pkg::ENG_MOD;
            end
          end
        end
      end
      sfd_pkg::ENG_MOD: begin
        if (mod_done) begin
          red_go    = 1'b1;
          state_nxt = sfd_pkg::ENG_RESP;
        end
      end
      sfd_pkg::ENG_MEM: begin
        pending_nxt = rdata_r;
        state_nxt   = sfd_pkg::ENG_RESP;
      end
      sfd_pkg::ENG_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = resp_r;
          out_valid_nxt = 1'b1;
          state_nxt     = sfd_pkg::ENG_IDLE;
        end
      end
      default: begin
        state_nxt = sfd_pkg::ENG_IDLE;
      end
    endcase

    if (red_go) begin
      case (it.op)
        sfd_pkg::OP_PRELOAD: begin
          mem_we    = 1'b1;
          mem_addr  = red_r;
          mem_wdata = it.value[7:0];
        end
        sfd_pkg::OP_RECEIVE: begin
          ptr_nxt   = sfd_pkg::PTR_W'(red_wrap);
          mem_re    = 1'b1;
          mem_addr  = red_wrap;
          state_nxt = sfd_pkg::ENG_MEM;
        end
        sfd_pkg::OP_TRANSMIT: begin
          ptr_nxt = sfd_pkg::PTR_W'(red_r);
          if (cmd_r == sfd_pkg::CMD_READ) begin
            mem_re    = 1'b1;
            mem_addr  = red_r;
            state_nxt = sfd_pkg::ENG_MEM;
          end
        end
        default: begin
          mem_re = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfd_pkg::ENG_CLEAR;
      cmd_r       <= sfd_pkg::CMD_STANDBY;
      phase_r     <= '0;
      ptr_r       <= '1;
      pending_r   <= '0;
      status_r    <= '0;
      bpl_r       <= '0;
      mode_word_r <= '0;
      id_r        <= sfd_pkg::ID_BYTES_RST;
      bpc_r       <= sfd_pkg::BUSY_POLLS_RST;
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      phase_r     <= phase_nxt;
      ptr_r       <= ptr_nxt;
      pending_r   <= pending_nxt;
      status_r    <= status_nxt;
      bpl_r       <= bpl_nxt;
      mode_word_r <= mode_word_nxt;
      id_r        <= id_nxt;
      bpc_r       <= bpc_nxt;
      out_valid_r <= out_valid_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    resp_r <= resp_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

endmodule

// ===== rtl/spi_serial_flash_device.sv =====
// ----------------------------------------------------------------------------
// Serial flash device
// Register window in front of a byte-wide serial flash command decoder.
//
//   Channel  Direction  Payload
//   in_ch    sink       func, offset, value, load_address
//   out_ch   source     read_data, error
//   cfg_*    write      cfg_index selects id_bytes or busy_poll_count
//
// Most words pass through the engine states ENG_IDLE and ENG_RESP; a receive
// during a read and the last address byte of a READ also pass through
// ENG_MEM, since the flash array has one port with a registered read.
// With a flash size that is not a power of two, an address at or above that
// size is reduced by a pipelined reciprocal unit in the engine state ENG_MOD.
// After reset the array is cleared to zero with in_ch.ready low.
// A two-word queue lets the front accept while a result waits on out_ch.
// ----------------------------------------------------------------------------
module spi_serial_flash_device #(
  parameter int FLASH_BYTES = sfd_pkg::FLASH_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sfd_in_if.sink                         in_ch,
  sfd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic               q_valid;
  logic               q_pop;
  logic               clearing;
  sfd_pkg::sfd_item_t q_item;

  sfd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .hold    (clearing),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  sfd_engine #(.FLASH_BYTES(FLASH_BYTES)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/sfd_checker.sv =====
// ----------------------------------------------------------------------------
// Serial flash device checker
// Port-level properties of the serial flash device, bound to the top level.
// ----------------------------------------------------------------------------
`include "spi_serial_flash_device_defines.svh"

module sfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_data,
  input logic [1:0]  out_error
);

  `SFD_ASSERT_RST(a_clear_after_reset, clk, !rst_n |=> !in_ready, "input ready during clearing")
  `SFD_ASSERT_RST(a_out_idle_after_reset, clk, !rst_n |=> !out_valid, "result word after reset")
  `SFD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_error), "stalled result word changed")
  `SFD_ASSERT(a_err_zero_data, clk, rst_n, out_valid && (out_error == sfd_pkg::ERR_OPCODE || out_error == sfd_pkg::ERR_WRITE) |-> out_read_data == 32'h0, "write error with read data")

endmodule

bind spi_serial_flash_device sfd_checker u_sfd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_read_data (out_ch.read_data),
  .out_error     (out_ch.error)
);

// ===== tb/sv/spi_serial_flash_device_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial flash device testbench
// Drives bus reads, bus writes, chip-select changes and preload words into
// the device under random idling and a long result stall. A built-in model
// of the command decoder and flash image predicts each result word that the
// directed table does not give itself. A short directed table comes first,
// then random command sequences under several register settings.
// ----------------------------------------------------------------------------
module spi_serial_flash_device_tb;

  localparam int FLASH_SIZE  = 65536;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    sfd_pkg::func_t func;
    logic [7:0]     offset;
    logic [31:0]    value;
    logic [15:0]    load_address;
    logic           known;
    logic [31:0]    want_data;
    sfd_pkg::err_t  want_err;
  } flash_req_t;

  localparam int DIR_ROWS = 26;
  localparam flash_req_t DIRECTED [DIR_ROWS] = '{
    '{sfd_pkg::FN_BUS_RD, sfd_pkg::OFS_BUSY, 32'h0, 16'h0, 1'b1, 32'h0, sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_RD, sfd_pkg::OFS_MODE, 32'h0, 16'h0, 1'b1, 32'h0, sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_RD, 8'hFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 32'h0, sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_RD, sfd_pkg::OFS_RX, 32'h0, 16'h0, 1'b1, 32'h0, sfd_pkg::ERR_READ},
    '{sfd_pkg::FN_BUS_WR, sfd_pkg::OFS_TX, 32'hFFFFFFFF, 16'h0, 1'b1, 32'h0,
      sfd_pkg::ERR_OPCODE},
    '{sfd_pkg::FN_BUS_WR, sfd_pkg::OFS_MODE_WORD, 32'hFFFFFFFF, 16'h0, 1'b1, 32'h0,
      sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_RD, sfd_pkg::OFS_MODE_WORD, 32'h0, 16'h0, 1'b1, 32'hFFFFFFFF,
      sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_PRELOAD, 8'h00, 32'hFFFFFFA5, 16'hFFFF, 1'b1, 32'h0, sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_WR, sfd_pkg::OFS_TX, {24'hFFFFFF, sfd_pkg::CMD_RDID}, 16'h0, 1'b0,
      32'h0, sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_RD, sfd_pkg::OFS_RX, 32'h0, 16'h0, 1'b0, 32'h0, sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_RD, sfd_pkg::OFS_RX, 32'h0, 16'h0, 1'b0, 32'h0, sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_RD, sfd_pkg::OFS_RX, 32'h0, 16'h0, 1'b0, 32'h0, sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_RD, sfd_pkg::OFS_RX, 32'h0, 16'h0, 1'b1, 32'h0, sfd_pkg::ERR_READ},
    '{sfd_pkg::FN_BUS_WR, sfd_pkg::OFS_TX, {24'h0, sfd_pkg::CMD_WREN}, 16'h0, 1'b0,
      32'h0, sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_WR, sfd_pkg::OFS_TX, {24'h0, sfd_pkg::CMD_RDSR}, 16'h0, 1'b0,
      32'h0, sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_WR, sfd_pkg::OFS_TX, 32'h0, 16'h0, 1'b1, 32'h0, sfd_pkg::ERR_WRITE},
    '{sfd_pkg::FN_BUS_RD, sfd_pkg::OFS_RX, 32'h0, 16'h0, 1'b0, 32'h0, sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_WR, sfd_pkg::OFS_TX, {24'h0, sfd_pkg::CMD_READ}, 16'h0, 1'b0,
      32'h0, sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_WR, sfd_pkg::OFS_TX, 32'hFFFFFFFF, 16'h0, 1'b0, 32'h0,
      sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_WR, sfd_pkg::OFS_TX, 32'hFFFFFFFF, 16'h0, 1'b0, 32'h0,
      sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_WR, sfd_pkg::OFS_TX, 32'hFFFFFFFF, 16'h0, 1'b0, 32'h0,
      sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_RD, sfd_pkg::OFS_RX, 32'h0, 16'h0, 1'b0, 32'h0, sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_RD, sfd_pkg::OFS_BUSY, 32'h0, 16'h0, 1'b0, 32'h0, sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_CS, 8'h00, 32'hFFFFFFFE, 16'h0, 1'b1, 32'h0, sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_CS, 8'h00, 32'h00000001, 16'h0, 1'b1, 32'h0, sfd_pkg::ERR_NONE},
    '{sfd_pkg::FN_BUS_WR, sfd_pkg::OFS_TX, {24'h0, sfd_pkg::CMD_POLL}, 16'h0, 1'b0,
      32'h0, sfd_pkg::ERR_NONE}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();

  spi_serial_flash_device uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model of the flash image and the command decoder.
  logic [7:0]    flash_img [FLASH_SIZE];
  sfd_pkg::cmd_t cmd_state;
  logic [1:0]    phase;
  logic [23:0]   ptr;
  logic [7:0]    pend;
  logic [7:0]    status;
  logic [3:0]    polls_left;
  logic [31:0]   mode_reg;
  logic [23:0]   id_reg;
  logic [3:0]    polls_reload;

  flash_req_t         stim_q [$];
  sfd_pkg::sfd_resp_t flash_replies_q [$];
  int                 fails;
  int                 results_seen;
  bit                 quiet;
  int                 hold_left;
  bit                 hold_done;

  always #4 clk = ~clk;

  initial begin
    #5_000_000;
    $display("spi_serial_flash_device verification failed");
    $finish;
  end

  function automatic void flash_reset_model();
    foreach (flash_img[i]) flash_img[i] = 8'h00;
    cmd_state    = sfd_pkg::CMD_STANDBY;
    phase        = 2'd0;
    ptr          = 24'hFFFFFF;
    pend         = 8'h00;
    status       = 8'h00;
    polls_left   = 4'd0;
    mode_reg     = 32'h0;
    id_reg       = sfd_pkg::ID_BYTES_RST;
    polls_reload = sfd_pkg::BUSY_POLLS_RST;
  endfunction

  function automatic logic [7:0] id_pick(input logic [2:0] k);
    case (k)
      3'd0:    return id_reg[23:16];
      3'd1:    return id_reg[15:8];
      3'd2:    return id_reg[7:0];
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic take_poll();
    if (polls_left != 4'd0) begin
      polls_left = polls_left - 4'd1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] flash_receive(output sfd_pkg::err_t err);
    logic [7:0]  ret;
    logic [15:0] p;
    ret = pend;
    err = sfd_pkg::ERR_NONE;
    case (cmd_state)
      sfd_pkg::CMD_READ, sfd_pkg::CMD_QREAD: begin
        p = ptr[15:0] + 16'd1;
        ptr = {8'h00, p};
        pend = flash_img[p];
        polls_left = polls_reload;
      end
      sfd_pkg::CMD_RDSR: cmd_state = sfd_pkg::CMD_STANDBY;
      sfd_pkg::CMD_RDID: begin
        pend = id_pick({1'b0, phase} + 3'd1);
        phase = phase + 2'd1;
        if (phase == 2'd3) begin
          cmd_state = sfd_pkg::CMD_STANDBY;
          phase = 2'd0;
        end
      end
      default: begin
        err = sfd_pkg::ERR_READ;
        pend = 8'h00;
      end
    endcase
    return ret;
  endfunction

  function automatic sfd_pkg::err_t flash_transmit(input logic [7:0] b);
    logic        addr_cmd;
    logic [15:0] p;
    addr_cmd = (cmd_state == sfd_pkg::CMD_READ) || (cmd_state == sfd_pkg::CMD_PP) ||
               (cmd_state == sfd_pkg::CMD_ARRAY) || (cmd_state == sfd_pkg::CMD_QREAD);
    if (cmd_state == sfd_pkg::CMD_STANDBY) begin
      case (b)
        sfd_pkg::CMD_WRSR: begin
          cmd_state = sfd_pkg::CMD_WRSR;
          status = 8'h00;
        end
        sfd_pkg::CMD_RDSR: begin
          pend = status;
          cmd_state = sfd_pkg::CMD_RDSR;
        end
        sfd_pkg::CMD_POLL: pend = {7'd0, take_poll()};
        sfd_pkg::CMD_WREN: status[sfd_pkg::WEL_BIT] = 1'b1;
        sfd_pkg::CMD_WRDI: status[sfd_pkg::WEL_BIT] = 1'b0;
        sfd_pkg::CMD_RDID: begin
          pend = id_pick(3'd0);
          cmd_state = sfd_pkg::CMD_RDID;
          phase = 2'd0;
        end
        sfd_pkg::CMD_READ, sfd_pkg::CMD_PP, sfd_pkg::CMD_ARRAY, sfd_pkg::CMD_QREAD: begin
          cmd_state = sfd_pkg::cmd_t'(b);
          phase = 2'd0;
          ptr = 24'h0;
          polls_left = 4'd0;
        end
        default: return sfd_pkg::ERR_OPCODE;
      endcase
      return sfd_pkg::ERR_NONE;
    end
    if (cmd_state == sfd_pkg::CMD_WRSR) begin
      status = b;
      cmd_state = sfd_pkg::CMD_STANDBY;
      phase = 2'd0;
      return sfd_pkg::ERR_NONE;
    end
    if (cmd_state == sfd_pkg::CMD_PP && phase == 2'd3) begin
      flash_img[ptr[15:0]] = b;
      cmd_state = sfd_pkg::CMD_STANDBY;
      phase = 2'd0;
      return sfd_pkg::ERR_NONE;
    end
    if (cmd_state == sfd_pkg::CMD_ARRAY && phase == 2'd3) begin
      flash_img[ptr[15:0]] = b;
      p = ptr[15:0] + 16'd1;
      ptr = {8'h00, p};
      return sfd_pkg::ERR_NONE;
    end
    if (addr_cmd && phase != 2'd3) begin
      case (phase)
        2'd0:    ptr[23:16] = ptr[23:16] | b;
        2'd1:    ptr[15:8] = ptr[15:8] | b;
        default: ptr[7:0] = ptr[7:0] | b;
      endcase
      phase = phase + 2'd1;
      if (phase == 2'd3) begin
        ptr = {8'h00, ptr[15:0]};
        if (cmd_state == sfd_pkg::CMD_READ) pend = flash_img[ptr[15:0]];
      end
      polls_left = polls_reload;
      return sfd_pkg::ERR_NONE;
    end
    return sfd_pkg::ERR_WRITE;
  endfunction

  function automatic sfd_pkg::sfd_resp_t flash_predict(input flash_req_t w);
    sfd_pkg::sfd_resp_t r;
    sfd_pkg::err_t      e;
    logic [7:0]         rx;
    r.read_data = 32'h0;
    r.error = sfd_pkg::ERR_NONE;
    case (w.func)
      sfd_pkg::FN_BUS_RD: begin
        if (w.offset == sfd_pkg::OFS_BUSY) begin
          r.read_data = {31'd0, take_poll()};
        end else if (w.offset == sfd_pkg::OFS_RX) begin
          rx = flash_receive(e);
          r.read_data = {24'd0, rx};
          r.error = e;
        end else if (w.offset == sfd_pkg::OFS_MODE_WORD) begin
          r.read_data = mode_reg;
        end
      end
      sfd_pkg::FN_BUS_WR: begin
        if (w.offset == sfd_pkg::OFS_TX) r.error = flash_transmit(w.value[7:0]);
        else if (w.offset == sfd_pkg::OFS_MODE_WORD) mode_reg = w.value;
      end
      sfd_pkg::FN_CS: begin
        if (w.value[0]) begin
          ptr = 24'hFFFFFF;
          cmd_state = sfd_pkg::CMD_STANDBY;
          phase = 2'd0;
          pend = 8'h00;
          polls_left = 4'd0;
        end
      end
      default: flash_img[w.load_address] = w.value[7:0];
    endcase
    return r;
  endfunction

  // Random stimulus building blocks.
  function automatic void push_word(input sfd_pkg::func_t f, input logic [7:0] ofs,
                                    input logic [31:0] v, input logic [15:0] a);
    flash_req_t w;
    w = '0;
    w.func = f;
    w.offset = ofs;
    w.value = v;
    w.load_address = a;
    stim_q.push_back(w);
  endfunction

  function automatic void push_tx(input logic [7:0] b);
    logic [31:0] v;
    v = $urandom();
    v[7:0] = b;
    push_word(sfd_pkg::FN_BUS_WR, sfd_pkg::OFS_TX, v, 16'($urandom()));
  endfunction

  function automatic void push_rx();
    push_word(sfd_pkg::FN_BUS_RD, sfd_pkg::OFS_RX, $urandom(), 16'($urandom()));
  endfunction

  function automatic void push_cs(input logic level);
    logic [31:0] v;
    v = $urandom();
    v[0] = level;
    push_word(sfd_pkg::FN_CS, 8'($urandom()), v, 16'($urandom()));
  endfunction

  function automatic logic [7:0] pick_page();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h01;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return sfd_pkg::OFS_BUSY;
      1:       return sfd_pkg::OFS_MODE;
      2:       return sfd_pkg::OFS_TX;
      3:       return sfd_pkg::OFS_RX;
      4:       return sfd_pkg::OFS_MODE_WORD;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic void push_address();
    push_tx(8'($urandom()));
    push_tx(pick_page());
    push_tx(8'($urandom()));
  endfunction

  function automatic void build_random(input int count);
    int n;
    int k;
    while (stim_q.size() < count) begin
      case ($urandom_range(0, 19))
        0, 1: push_word(sfd_pkg::func_t'($urandom_range(0, 3)), pick_offset(), $urandom(),
                        16'($urandom()));
        2: begin
          n = $urandom_range(2, 6);
          for (k = 0; k < n; k++)
            push_word(sfd_pkg::FN_PRELOAD, 8'($urandom()), $urandom(),
                      {pick_page(), 8'($urandom())});
        end
        3, 4, 5, 6, 18, 19: begin
          push_tx(($urandom_range(0, 2) == 0) ? sfd_pkg::CMD_QREAD : sfd_pkg::CMD_READ);
          push_address();
          n = $urandom_range(1, 8);
          for (k = 0; k < n; k++) begin
            push_rx();
            if ($urandom_range(0, 4) == 0)
              push_word(sfd_pkg::FN_BUS_RD, sfd_pkg::OFS_BUSY, $urandom(), 16'h0);
          end
          if ($urandom_range(0, 9) < 7) push_cs(1'b1);
        end
        7, 8: begin
          if ($urandom_range(0, 1) == 0) push_tx(sfd_pkg::CMD_WREN);
          push_tx(sfd_pkg::CMD_PP);
          push_address();
          push_tx(8'($urandom()));
          if ($urandom_range(0, 3) == 0) push_tx(8'($urandom()));
          push_cs(1'b1);
        end
        9, 10: begin
          push_tx(sfd_pkg::CMD_ARRAY);
          push_address();
          n = $urandom_range(1, 6);
          for (k = 0; k < n; k++) push_tx(8'($urandom()));
          push_cs(1'b1);
        end
        11: begin
          push_tx(sfd_pkg::CMD_RDID);
          n = $urandom_range(1, 5);
          for (k = 0; k < n; k++) push_rx();
          if ($urandom_range(0, 1) == 0) push_cs(1'b1);
        end
        12: begin
          if ($urandom_range(0, 1) == 0) begin
            push_tx(sfd_pkg::CMD_RDSR);
            n = $urandom_range(1, 2);
            for (k = 0; k < n; k++) push_rx();
          end else begin
            push_tx(sfd_pkg::CMD_WRSR);
            push_tx(8'($urandom()));
          end
        end
        13: begin
          case ($urandom_range(0, 2))
            0:       push_tx(sfd_pkg::CMD_WREN);
            1:       push_tx(sfd_pkg::CMD_WRDI);
            default: push_tx(sfd_pkg::CMD_POLL);
          endcase
          if ($urandom_range(0, 1) == 0) push_rx();
        end
        14: begin
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++)
            push_word(sfd_pkg::FN_BUS_RD, sfd_pkg::OFS_BUSY, $urandom(), 16'($urandom()));
        end
        15: begin
          push_word(sfd_pkg::FN_BUS_WR, sfd_pkg::OFS_MODE_WORD, $urandom(), 16'($urandom()));
          push_word(sfd_pkg::FN_BUS_RD, sfd_pkg::OFS_MODE_WORD, $urandom(), 16'($urandom()));
          push_word(sfd_pkg::FN_BUS_RD, sfd_pkg::OFS_MODE, $urandom(), 16'($urandom()));
        end
        16: push_cs(1'($urandom_range(0, 1)));
        default: begin
          push_tx(($urandom_range(0, 1) == 0) ? sfd_pkg::CMD_READ : sfd_pkg::CMD_ARRAY);
          n = $urandom_range(1, 2);
          for (k = 0; k < n; k++) push_tx(8'($urandom()));
          if ($urandom_range(0, 1) == 0) push_rx();
          else push_cs(1'b1);
        end
      endcase
    end
  endfunction

  task automatic send_word(input flash_req_t w);
    sfd_pkg::sfd_resp_t pred;
    sfd_pkg::sfd_resp_t typed;
    while (!quiet && $urandom_range(0, 99) < 27) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= w.func;
    in_ch.offset       <= w.offset;
    in_ch.value        <= w.value;
    in_ch.load_address <= w.load_address;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pred = flash_predict(w);
    if (w.known) begin
      typed.read_data = w.want_data;
      typed.error = w.want_err;
      flash_replies_q.push_back(typed);
    end else begin
      flash_replies_q.push_back(pred);
    end
  endtask

  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    while (flash_replies_q.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings(input logic [23:0] ids, input logic [3:0] polls);
    cfg_we    <= 1'b1;
    cfg_index <= sfd_pkg::CFG_ID_BYTES;
    cfg_data  <= ids;
    @(posedge clk);
    cfg_index <= sfd_pkg::CFG_BUSY_POLLS;
    cfg_data  <= {20'd0, polls};
    @(posedge clk);
    cfg_we <= 1'b0;
    id_reg = ids;
    polls_reload = polls;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet || ($urandom_range(0, 99) >= 27);
    end
  end

  always @(posedge clk) begin
    sfd_pkg::sfd_resp_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (flash_replies_q.size() == 0) begin
        fails++;
        if (fails < MAX_REPORTS)
          $display("%0t: unexpected word, expected none, actual read_data %h error %0d",
                   $time, out_ch.read_data, out_ch.error);
      end else begin
        want = flash_replies_q.pop_front();
        if (out_ch.read_data !== want.read_data) begin
          fails++;
          if (fails < MAX_REPORTS)
            $display("%0t: read_data mismatch, expected %h actual %h",
                     $time, want.read_data, out_ch.read_data);
        end
        if (out_ch.error !== want.error) begin
          fails++;
          if (fails < MAX_REPORTS)
            $display("%0t: error mismatch, expected %0d actual %0d",
                     $time, want.error, out_ch.error);
        end
      end
    end
  end

  initial begin : main
    int ph;
    int sent;
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.func         = 2'd0;
    in_ch.offset       = 8'h00;
    in_ch.value        = 32'h0;
    in_ch.load_address = 16'h0;
    out_ch.ready       = 1'b0;
    fails              = 0;
    results_seen       = 0;
    quiet              = 1'b0;
    hold_left          = 0;
    hold_done          = 1'b0;
    flash_reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_word(DIRECTED[i]);
    drain_replies();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       load_settings(24'h000000, 4'd0);
        1:       load_settings(24'hFFFFFF, 4'hF);
        default: load_settings(24'($urandom()), 4'($urandom_range(1, 14)));
      endcase
      build_random(230);
      sent = 0;
      while (stim_q.size() != 0) begin
        quiet = (ph == 1) && (sent >= 40) && (sent < 160);
        send_word(stim_q.pop_front());
        sent++;
      end
      quiet = 1'b0;
      drain_replies();
    end

    repeat (16) @(posedge clk);
    if (fails == 0 && flash_replies_q.size() == 0) begin
      $display("spi_serial_flash_device verification clean");
    end else begin
      $display("spi_serial_flash_device verification failed");
    end
    $finish;
  end

endmodule
